>>> rtl/wnm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wnm_pkg
// Shared constants and types for the wildcard name matcher: the wildcard
// characters, the pattern register widths and the configuration register indexes.
// ----------------------------------------------------------------------------
package wnm_pkg;

	localparam logic [7:0] STAR_CHAR = 8'h2A;
	localparam logic [7:0] ANY_CHAR  = 8'h2E;

	localparam int PATTERN_BYTES_W = 64;
	localparam int PATTERN_COUNT_W = 4;

	typedef enum logic [1:0] {
		REG_PATTERN_BYTES  = 2'd0,
		REG_PATTERN_COUNT  = 2'd1,
		REG_PATTERN_ENABLE = 2'd2
	} cfg_reg_t;

endpackage

>>> rtl/wnm_nfa_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wnm_nfa_step
// One character step of the bit-vector NFA: close the active set over
// stars, advance on the name byte, close again. Also gives the re-armed set
// and whether the final position is reached.
// ----------------------------------------------------------------------------
module wnm_nfa_step #(
	parameter int PATTERN_LEN = 8
) (
	input  logic [PATTERN_LEN:0]                 active,
	input  logic [7:0]                           name_byte,
	input  logic [wnm_pkg::PATTERN_BYTES_W-1:0]  pattern_bytes,
	input  logic [wnm_pkg::PATTERN_COUNT_W-1:0]  pattern_count,
	output logic [PATTERN_LEN:0]                 next_set,
	output logic [PATTERN_LEN:0]                 rearm_set,
	output logic                                 hit
);
	import wnm_pkg::*;

	localparam int CW = $clog2(PATTERN_LEN + 1);

	logic [CW-1:0]          used_len;
	logic [PATTERN_LEN:0]   live;
	logic [PATTERN_LEN-1:0] star;
	logic [PATTERN_LEN-1:0] advance;
	logic [PATTERN_LEN:0]   cur;
	logic [PATTERN_LEN:0]   raw_next;

	function automatic logic [PATTERN_LEN:0] close_stars(
		input logic [PATTERN_LEN:0]   set_in,
		input logic [PATTERN_LEN:0]   live_in,
		input logic [PATTERN_LEN-1:0] star_in
	);
		logic [PATTERN_LEN:0] s;
		s = set_in & live_in;
		for (int i = 0; i < PATTERN_LEN; i++) begin
			if (s[i] && star_in[i]) begin
				s[i+1] = 1'b1;
			end
		end
		return s;
	endfunction

	always_comb begin
		if (pattern_count > PATTERN_COUNT_W'(PATTERN_LEN)) begin
			used_len = CW'(PATTERN_LEN);
		end else begin
			used_len = pattern_count[CW-1:0];
		end
	end

	always_comb begin
		for (int i = 0; i <= PATTERN_LEN; i++) begin
			live[i] = (i <= int'(used_len));
		end
		for (int i = 0; i < PATTERN_LEN; i++) begin
			star[i]    = (i < int'(used_len)) && (pattern_bytes[8*i +: 8] == STAR_CHAR);
			advance[i] = (i < int'(used_len)) && !star[i] &&
				((pattern_bytes[8*i +: 8] == ANY_CHAR) ||
				 (pattern_bytes[8*i +: 8] == name_byte));
		end
	end

	always_comb begin
		cur      = close_stars(active, live, star);
		raw_next = '0;
		for (int i = 0; i < PATTERN_LEN; i++) begin
			if (cur[i] && star[i]) begin
				raw_next[i] = 1'b1;
			end
			if (cur[i] && advance[i]) begin
				raw_next[i+1] = 1'b1;
			end
		end
		next_set  = close_stars(raw_next, live, star);
		rearm_set = close_stars((PATTERN_LEN+1)'(1), live, star);
		hit       = next_set[used_len];
	end

endmodule

>>> rtl/wildcard_name_matcher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wildcard_name_matcher
// Flow: the final name byte is registered in byte_s1/end_s1, then its result
// in match_valid/matched. Throughput: one name byte per cycle while name_stall
// is low; the active set updates once per byte through a single NFA step.
// Reset: pattern registers clear to zero (pattern disabled, empty), the
// active set holds position zero only, no request is in flight.
// ----------------------------------------------------------------------------
// Matches a streamed file name against a wildcard pattern ('*' any run,
// '.' any byte) and reports the outcome on the last byte of each name.
// ----------------------------------------------------------------------------
module wildcard_name_matcher #(
	parameter int PATTERN_LEN = 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [1:0]                           cfg_index,
	input  logic [wnm_pkg::PATTERN_BYTES_W-1:0]  cfg_data,
	input  logic                                 name_valid,
	output logic                                 name_stall,
	input  logic [7:0]                           name_byte,
	input  logic                                 name_end,
	output logic                                 match_valid,
	input  logic                                 match_stall,
	output logic                                 matched
);
	import wnm_pkg::*;

	logic [PATTERN_BYTES_W-1:0] pattern_bytes_q;
	logic [PATTERN_COUNT_W-1:0] pattern_count_q;
	logic                       pattern_enable_q;

	logic                 valid_s1;
	logic [7:0]           byte_s1;
	logic                 end_s1;
	logic [PATTERN_LEN:0] active_q;
	logic                 match_valid_q;
	logic                 matched_q;

	logic [PATTERN_LEN:0] next_set;
	logic [PATTERN_LEN:0] rearm_set;
	logic                 hit;
	logic                 adv;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_bytes_q  <= '0;
			pattern_count_q  <= '0;
			pattern_enable_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_PATTERN_BYTES:  pattern_bytes_q  <= cfg_data;
				REG_PATTERN_COUNT:  pattern_count_q  <= cfg_data[PATTERN_COUNT_W-1:0];
				REG_PATTERN_ENABLE: pattern_enable_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	wnm_nfa_step #(
		.PATTERN_LEN(PATTERN_LEN)
	) u_step (
		.active        (active_q),
		.name_byte     (byte_s1),
		.pattern_bytes (pattern_bytes_q),
		.pattern_count (pattern_count_q),
		.next_set      (next_set),
		.rearm_set     (rearm_set),
		.hit           (hit)
	);

	assign adv        = valid_s1 && (!end_s1 || !match_valid_q || !match_stall);
	assign name_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!name_stall) begin
			valid_s1 <= name_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!name_stall) begin
			byte_s1 <= name_byte;
			end_s1  <= name_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= (PATTERN_LEN+1)'(1);
		end else if (adv) begin
			active_q <= end_s1 ? rearm_set : next_set;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_valid_q <= 1'b0;
		end else if (!match_valid_q || !match_stall) begin
			match_valid_q <= adv && end_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && end_s1) begin
			matched_q <= pattern_enable_q && hit;
		end
	end

	assign match_valid = match_valid_q;
	assign matched     = matched_q;

	a_end_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && end_s1) |=> match_valid_q)
		else $error("final byte did not produce a result");

	a_match_needs_enable: assert property (@(posedge clk) disable iff (!arst_n)
		(match_valid_q && matched_q) |-> pattern_enable_q)
		else $error("match reported with pattern disabled");

	a_stall_only_when_held: assert property (@(posedge clk) disable iff (!arst_n)
		name_stall |-> (valid_s1 && end_s1 && match_valid_q && match_stall))
		else $error("input stalled without a blocked result");

	a_rearm_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && end_s1) |=> active_q[0])
		else $error("active set not re-armed after final byte");

endmodule

>>> dv/wildcard_name_matcher_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wildcard_name_matcher_checker
// Watches the configuration, name and match channels of the wildcard name
// matcher. It keeps its own copy of the pattern registers and of the active
// pattern positions, works out the match flag for every name byte marked last,
// and compares each accepted match result with the oldest outstanding flag.
// ----------------------------------------------------------------------------
module wildcard_name_matcher_checker
	import wnm_pkg::*;
#(
	parameter int PATTERN_LEN = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	input  logic                         cfg_ready,
	input  logic [1:0]                   cfg_index,
	input  logic [PATTERN_BYTES_W-1:0]   cfg_data,
	input  logic                         name_valid,
	input  logic                         name_stall,
	input  logic [7:0]                   name_byte,
	input  logic                         name_end,
	input  logic                         match_valid,
	input  logic                         match_stall,
	input  logic                         matched,
	output int                           mismatches,
	output int                           outstanding
);

	logic [PATTERN_BYTES_W-1:0] pattern_chars;
	logic [PATTERN_COUNT_W-1:0] pattern_count;
	logic                       pattern_on;
	logic [PATTERN_LEN:0]       live_positions;
	bit                         pending_matches[$];
	int                         fail_count;

	function automatic int used_length();
		return (pattern_count > PATTERN_LEN) ? PATTERN_LEN : int'(pattern_count);
	endfunction

	function automatic logic [7:0] pattern_char(input int i);
		return pattern_chars[8*i +: 8];
	endfunction

	function automatic logic [PATTERN_LEN:0] star_closure(input logic [PATTERN_LEN:0] set);
		int n;
		logic [PATTERN_LEN+1:0] mask;
		logic [PATTERN_LEN:0] s;
		n = used_length();
		mask = ({{(PATTERN_LEN+1){1'b0}}, 1'b1} << (n + 1)) - 1'b1;
		s = set & mask[PATTERN_LEN:0];
		for (int i = 0; i < n; i++) begin
			if (s[i] && pattern_char(i) == STAR_CHAR)
				s[i+1] = 1'b1;
		end
		return s;
	endfunction

	function automatic logic [PATTERN_LEN:0] advance_positions(input logic [PATTERN_LEN:0] cur,
			input logic [7:0] c);
		int n;
		logic [PATTERN_LEN:0] s;
		n = used_length();
		s = '0;
		for (int i = 0; i < n; i++) begin
			if (cur[i]) begin
				if (pattern_char(i) == STAR_CHAR)
					s[i] = 1'b1;
				else if (pattern_char(i) == ANY_CHAR || pattern_char(i) == c)
					s[i+1] = 1'b1;
			end
		end
		return star_closure(s);
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		logic [PATTERN_LEN:0] next_set;
		bit want;
		if (!arst_n) begin
			pattern_chars = '0;
			pattern_count = '0;
			pattern_on = 1'b0;
			live_positions = star_closure({{PATTERN_LEN{1'b0}}, 1'b1});
			pending_matches.delete();
			fail_count = 0;
		end else begin
			if (match_valid && !match_stall) begin
				if (pending_matches.size() == 0) begin
					$display("%0t: unexpected match result: expected none, actual matched=%0b",
						$time, matched);
					fail_count++;
				end else begin
					want = pending_matches.pop_front();
					if (matched !== want) begin
						$display("%0t: matched mismatch: expected %0b, actual %0b",
							$time, want, matched);
						fail_count++;
					end
				end
			end
			if (name_valid && !name_stall) begin
				next_set = advance_positions(star_closure(live_positions), name_byte);
				if (name_end) begin
					pending_matches.push_back(pattern_on && next_set[used_length()]);
					live_positions = star_closure({{PATTERN_LEN{1'b0}}, 1'b1});
				end else begin
					live_positions = next_set;
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_PATTERN_BYTES:  pattern_chars = cfg_data;
					REG_PATTERN_COUNT:  pattern_count = cfg_data[PATTERN_COUNT_W-1:0];
					REG_PATTERN_ENABLE: pattern_on = cfg_data[0];
					default: ;
				endcase
			end
		end
		mismatches <= fail_count;
		outstanding <= pending_matches.size();
	end

endmodule

>>> dv/wildcard_name_matcher_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wildcard_name_matcher_test
// Drives file names byte by byte into the wildcard name matcher under a
// series of patterns: a directed set covering wildcards, zero bytes, empty,
// disabled and oversized patterns and an unused register index, then random
// patterns with names mostly built to fit them. Both channels idle at random;
// the checker beside the block predicts and compares every match result.
// ----------------------------------------------------------------------------
module wildcard_name_matcher_test;
	import wnm_pkg::*;

	localparam logic [1:0] REG_UNUSED     = 2'd3;
	localparam int         IDLE_PCT       = 31;
	localparam int         SETTLE_CYCLES  = 4;
	localparam int         RANDOM_ITEMS   = 550;
	localparam int         WATCHDOG_LIMIT = 1000;

	typedef logic [7:0] name_q_t[$];

	logic                       clk;
	logic                       arst_n = 1'b0;
	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic [1:0]                 cfg_index = '0;
	logic [PATTERN_BYTES_W-1:0] cfg_data = '0;
	logic                       name_valid = 1'b0;
	logic                       name_stall;
	logic [7:0]                 name_byte = '0;
	logic                       name_end = 1'b0;
	logic                       match_valid;
	logic                       match_stall = 1'b0;
	logic                       matched;
	int                         mismatches;
	int                         outstanding;
	bit                         steady = 1'b0;
	int                         items_sent = 0;
	int                         stuck_cycles = 0;

	wildcard_name_matcher dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.name_valid  (name_valid),
		.name_stall  (name_stall),
		.name_byte   (name_byte),
		.name_end    (name_end),
		.match_valid (match_valid),
		.match_stall (match_stall),
		.matched     (matched)
	);

	wildcard_name_matcher_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.name_valid  (name_valid),
		.name_stall  (name_stall),
		.name_byte   (name_byte),
		.name_end    (name_end),
		.match_valid (match_valid),
		.match_stall (match_stall),
		.matched     (matched),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		match_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
	end

	always @(posedge clk) begin
		if (!arst_n || (cfg_valid && cfg_ready) || (name_valid && !name_stall) ||
				(match_valid && !match_stall)) begin
			stuck_cycles <= 0;
		end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
	end

	function automatic name_q_t text_of(input string s);
		name_q_t q;
		for (int i = 0; i < s.len(); i++)
			q.push_back(s[i]);
		return q;
	endfunction

	function automatic logic [63:0] pattern_word(input string s);
		logic [63:0] w;
		w = '0;
		for (int i = 0; i < s.len() && i < 8; i++)
			w[8*i +: 8] = s[i];
		return w;
	endfunction

	function automatic logic [7:0] rand_name_char();
		int r;
		r = $urandom_range(99);
		if (r < 60)
			return 8'h61 + 8'($urandom_range(2));
		if (r < 70)
			return $urandom_range(1) ? STAR_CHAR : ANY_CHAR;
		return 8'($urandom_range(255));
	endfunction

	function automatic logic [7:0] rand_pattern_char();
		int r;
		r = $urandom_range(99);
		if (r < 35)
			return STAR_CHAR;
		if (r < 55)
			return ANY_CHAR;
		if (r < 90)
			return 8'h61 + 8'($urandom_range(1));
		return 8'($urandom_range(255));
	endfunction

	task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// write all pattern registers, then optionally poke the unused index
	task automatic load_pattern(input logic [63:0] word, input logic [3:0] count,
			input logic enable, input bit poke_unused, input logic [63:0] junk);
		write_reg(REG_PATTERN_BYTES, word);
		write_reg(REG_PATTERN_COUNT, {$urandom(), 28'($urandom()), count});
		write_reg(REG_PATTERN_ENABLE, {$urandom(), 31'($urandom()), enable});
		if (poke_unused)
			write_reg(REG_UNUSED, junk);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_byte(input logic [7:0] b, input logic last);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			name_valid <= 1'b0;
			@(posedge clk);
		end
		name_valid <= 1'b1;
		name_byte <= b;
		name_end <= last;
		do @(posedge clk); while (name_stall);
		items_sent++;
	endtask

	task automatic send_name(input name_q_t q);
		for (int i = 0; i < q.size(); i++)
			send_byte(q[i], i == q.size() - 1);
	endtask

	// hold the sender until every outstanding request has produced its result
	task automatic settle();
		name_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		logic [63:0] word;
		logic [3:0]  count;
		logic [7:0]  c;
		int          used;
		int          random_goal;
		int          phase;
		name_q_t     nm;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_name(text_of("q"));
		settle();
		load_pattern(pattern_word("a*b"), 4'd3, 1'b1, 1'b1, '1);
		send_name(text_of("ab"));
		send_name(text_of("aXYb"));
		send_name(text_of("ba"));
		settle();
		load_pattern(pattern_word("a*b"), 4'd3, 1'b0, 1'b0, '0);
		send_name(text_of("ab"));
		settle();
		load_pattern(64'h2A2A_2A2A_2A2A_002E, 4'd15, 1'b1, 1'b0, '0);
		send_name('{8'hFF, 8'h00});
		send_name('{8'h00, 8'h01, 8'h80});
		settle();
		load_pattern('1, 4'd0, 1'b1, 1'b0, '0);
		send_name(text_of("a"));
		settle();
		load_pattern('1, 4'd3, 1'b1, 1'b0, '0);
		send_name('{8'hFF, 8'hFF, 8'hFF});
		settle();
		load_pattern(pattern_word("********"), 4'd8, 1'b1, 1'b0, '0);
		send_name(text_of("z"));
		settle();
		load_pattern(pattern_word("."), 4'd1, 1'b1, 1'b0, '0);
		send_name('{8'h00});
		send_name(text_of("xy"));

		random_goal = items_sent + RANDOM_ITEMS;
		phase = 0;
		while (items_sent < random_goal) begin
			settle();
			for (int i = 0; i < 8; i++)
				word[8*i +: 8] = rand_pattern_char();
			case ($urandom_range(19))
				0:       count = 4'd0;
				1, 2:    count = 4'($urandom_range(9, 15));
				default: count = 4'($urandom_range(1, 8));
			endcase
			load_pattern(word, count, $urandom_range(99) < 85, $urandom_range(9) == 0,
				{$urandom(), $urandom()});
			steady <= (phase >= 4 && phase < 8);
			used = (count > 4'd8) ? 8 : int'(count);
			repeat ($urandom_range(3, 8)) begin
				nm.delete();
				if ($urandom_range(99) < 20) begin
					repeat ($urandom_range(1, 10)) nm.push_back(rand_name_char());
				end else begin
					for (int i = 0; i < used; i++) begin
						c = word[8*i +: 8];
						if (c == STAR_CHAR)
							repeat ($urandom_range(3)) nm.push_back(rand_name_char());
						else if (c == ANY_CHAR)
							nm.push_back(rand_name_char());
						else
							nm.push_back(c);
					end
					if (nm.size() != 0 && $urandom_range(99) < 20) begin
						case ($urandom_range(2))
							0:       nm[$urandom_range(nm.size() - 1)] = rand_name_char();
							1:       void'(nm.pop_back());
							default: nm.push_back(rand_name_char());
						endcase
					end
				end
				if (nm.size() == 0)
					nm.push_back(rand_name_char());
				send_name(nm);
			end
			phase++;
		end

		settle();
		if (mismatches == 0 && outstanding == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

>>> sim.f
rtl/wnm_pkg.sv
rtl/wnm_nfa_step.sv
rtl/wildcard_name_matcher.sv
dv/wildcard_name_matcher_checker.sv
dv/wildcard_name_matcher_test.sv
